>>> hw/rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros shared by the RTL
// Concurrent checks on the block clock, switched off while reset is high.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication
`define ASSERT_IMPL(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("same-cycle implication failed");

// Next-cycle implication
`define ASSERT_NEXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("next-cycle implication failed");

`endif

>>> hw/rtl/swact_pkg.sv
// ----------------------------------------------------------------------------
// swact_pkg
// Constants and elaboration-time table builder for the swish activation core.
// ----------------------------------------------------------------------------
package swact_pkg;

   localparam int LUT_ENTRIES_DEF = 256;
   localparam int LUT_MIN         = 32;
   localparam int LUT_MAX         = 4096;

   localparam int DATA_W = 16;            // Q8.8 samples, Q4.12 gain
   localparam int PROD_W = 32;            // gain * sample, Q.20
   localparam int FRAC_W = 24;            // interpolation fraction, Q0.24
   localparam int SIG_W  = 17;            // sigmoid value, Q0.16 up to 1.0
   localparam int DLT_W  = SIG_W + 1;     // signed step between neighbours
   localparam int ACC_W  = 44;            // interpolation accumulator
   localparam int MUL_W  = 34;            // sample * sigmoid
   localparam int YW_W   = MUL_W - 16;    // result before saturation

   localparam logic signed [DATA_W-1:0] ALPHA_RESET = 16'sd4096;
   localparam logic signed [PROD_W-1:0] SIG_LIM     = 32'sh0080_0000;
   localparam logic [SIG_W-1:0]         SIG_ONE     = 17'h1_0000;
   localparam logic signed [ACC_W-1:0]  ACC_HALF    = 44'sh000_0080_0000;
   localparam logic signed [MUL_W-1:0]  MUL_HALF    = 34'sh0_0000_8000;
   localparam logic signed [YW_W-1:0]   Y_MAX       = 18'sh0_7FFF;
   localparam logic signed [YW_W-1:0]   Y_MIN       = -18'sh0_8000;

   // Restoring long division, used only while building the table
   function automatic logic [63:0] udiv64(input logic [63:0] num,
                                          input logic [63:0] den);
      logic [63:0] q;
      logic [64:0] r;
      q = '0;
      r = '0;
      for (int b = 63; b >= 0; b--) begin
         r = {r[63:0], num[b]};
         if (r >= {1'b0, den}) begin
            r    = r - {1'b0, den};
            q[b] = 1'b1;
         end
      end
      return q;
   endfunction

   // Sigmoid at z = -8 + 16*k/n in Q0.16: series for exp(-|z|/256), then
   // eight squarings give exp(-|z|), then 1 / (1 + exp(-|z|)).
   function automatic logic [SIG_W-1:0] sig_rom_entry(input int unsigned k,
                                                      input int unsigned n);
      logic [63:0] one;
      logic [63:0] nn;
      logic [63:0] hi;
      logic [63:0] mid;
      logic [63:0] d;
      logic [63:0] u;
      logic [63:0] u2;
      logic [63:0] u3;
      logic [63:0] u4;
      logic [63:0] e;
      logic [63:0] den;
      logic [63:0] sp;
      logic        neg;
      one = 64'd1 << 31;
      nn  = 64'(n);
      hi  = 64'(k) * 64'd16;
      mid = nn * 64'd8;
      neg = hi < mid;
      d   = neg ? mid - hi : hi - mid;
      u   = udiv64((d << 23) + (nn >> 1), nn);
      u2  = (u * u + (64'd1 << 30)) >> 31;
      u3  = (u2 * u + (64'd1 << 30)) >> 31;
      u4  = (u3 * u + (64'd1 << 30)) >> 31;
      e   = one - u + (u2 >> 1) - u3 / 64'd6 + u4 / 64'd24;
      for (int sq = 0; sq < 8; sq++) begin
         e = (e * e + (64'd1 << 30)) >> 31;
      end
      den = one + e;
      sp  = udiv64((64'd1 << 47) + (den >> 1), den);
      return neg ? SIG_W'(64'd65536 - sp) : SIG_W'(sp);
   endfunction

endpackage

>>> hw/rtl/swish_activation_core.sv
// ----------------------------------------------------------------------------
// swish_activation_core
// Takes one item per cycle while the output is not held back by rsp_ready.
// Five register stages: gain multiply, table position, table read,
// interpolation, output multiply and rounding. Each stage has its own valid
// bit and holds independently, so bubbles close up behind a stalled result.
// Reset (synchronous) empties the pipe and sets the gain to 1.0.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module swish_activation_core #(
   parameter int LUT_ENTRIES = swact_pkg::LUT_ENTRIES_DEF
) (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    csr_wr_en,
   input  logic signed [swact_pkg::DATA_W-1:0]     csr_wr_data,
   input  logic                                    req_valid,
   output logic                                    req_ready,
   input  logic signed [swact_pkg::DATA_W-1:0]     req_x_value,
   output logic                                    rsp_valid,
   input  logic                                    rsp_ready,
   output logic signed [swact_pkg::DATA_W-1:0]     rsp_y_value
);

   localparam int LUT_N = (LUT_ENTRIES < swact_pkg::LUT_MIN) ? swact_pkg::LUT_MIN :
                          ((LUT_ENTRIES > swact_pkg::LUT_MAX) ? swact_pkg::LUT_MAX :
                           LUT_ENTRIES);
   localparam int IDX_W = $clog2(LUT_N);
   localparam int POS_W = swact_pkg::FRAC_W + IDX_W;
   localparam logic [POS_W-1:0] N_MULT = POS_W'(LUT_N);

   // Table: base value and step to the next entry (flat on the last one)
   logic [swact_pkg::SIG_W-1:0]        rom_base_w  [LUT_N];
   logic signed [swact_pkg::DLT_W-1:0] rom_delta_w [LUT_N];

   for (genvar k = 0; k < LUT_N; k++) begin : g_rom
      localparam int KN = (k + 1 < LUT_N) ? k + 1 : k;
      localparam logic [swact_pkg::SIG_W-1:0] BASE =
         swact_pkg::sig_rom_entry(k, LUT_N);
      localparam logic [swact_pkg::SIG_W-1:0] NEXT =
         swact_pkg::sig_rom_entry(KN, LUT_N);
      assign rom_base_w[k]  = BASE;
      assign rom_delta_w[k] = $signed({1'b0, NEXT}) - $signed({1'b0, BASE});
   end

   // Configuration
   logic signed [swact_pkg::DATA_W-1:0] alpha_gain_ff;
   logic signed [swact_pkg::DATA_W-1:0] alpha_gain_in;

   // Stage registers
   logic                                 v1_ff, v2_ff, v3_ff, v4_ff, rsp_valid_ff;
   logic signed [swact_pkg::DATA_W-1:0]  x1_ff, x2_ff, x3_ff, x4_ff;
   logic signed [swact_pkg::PROD_W-1:0]  p1_ff, p1_in;
   logic                                 lo2_ff, hi2_ff, lo2_in, hi2_in;
   logic [POS_W-1:0]                     pos2_ff, pos2_in;
   logic                                 lo3_ff, hi3_ff;
   logic [swact_pkg::SIG_W-1:0]          base3_ff, base3_in;
   logic signed [swact_pkg::DLT_W-1:0]   delta3_ff, delta3_in;
   logic [swact_pkg::FRAC_W-1:0]         frac3_ff, frac3_in;
   logic [swact_pkg::SIG_W-1:0]          sig4_ff, sig4_in;
   logic signed [swact_pkg::DATA_W-1:0]  y5_ff, y5_in;

   logic adv1, adv2, adv3, adv4, adv5;

   // Combinational working values
   logic signed [swact_pkg::PROD_W-1:0]  t2;
   logic [IDX_W-1:0]                     idx3;
   logic signed [swact_pkg::ACC_W-1:0]   acc4;
   logic signed [swact_pkg::MUL_W-1:0]   mul5;
   logic signed [swact_pkg::YW_W-1:0]    yw5;

   // Each stage moves on when it is empty or the stage after it moves on
   assign adv5      = !rsp_valid_ff || rsp_ready;
   assign adv4      = !v4_ff || adv5;
   assign adv3      = !v3_ff || adv4;
   assign adv2      = !v2_ff || adv3;
   assign adv1      = !v1_ff || adv2;
   assign req_ready = adv1;

   assign alpha_gain_in = csr_wr_en ? csr_wr_data : alpha_gain_ff;

   always_comb begin
      // stage 1: gain times sample, Q.20
      p1_in = alpha_gain_ff * req_x_value;

      // stage 2: clamp flags and table position
      lo2_in  = p1_ff < -swact_pkg::SIG_LIM;
      hi2_in  = p1_ff >= swact_pkg::SIG_LIM;
      t2      = p1_ff + swact_pkg::SIG_LIM;
      pos2_in = {{IDX_W{1'b0}}, t2[swact_pkg::FRAC_W-1:0]} * N_MULT;

      // stage 3: table read
      idx3      = pos2_ff[POS_W-1:swact_pkg::FRAC_W];
      frac3_in  = pos2_ff[swact_pkg::FRAC_W-1:0];
      base3_in  = rom_base_w[idx3];
      delta3_in = rom_delta_w[idx3];

      // stage 4: linear interpolation, round to nearest
      acc4 = $signed({3'b000, base3_ff, {swact_pkg::FRAC_W{1'b0}}})
           + swact_pkg::ACC_W'(delta3_ff * $signed({1'b0, frac3_ff}))
           + swact_pkg::ACC_HALF;
      if (lo3_ff) begin
         sig4_in = '0;
      end else if (hi3_ff) begin
         sig4_in = swact_pkg::SIG_ONE;
      end else if (acc4 < 0) begin
         sig4_in = '0;
      end else begin
         sig4_in = acc4[swact_pkg::FRAC_W +: swact_pkg::SIG_W];
      end

      // stage 5: sample times sigmoid, round, saturate
      mul5 = swact_pkg::MUL_W'(x4_ff * $signed({1'b0, sig4_ff})) + swact_pkg::MUL_HALF;
      yw5  = mul5[swact_pkg::MUL_W-1:16];
      if (yw5 > swact_pkg::Y_MAX) begin
         y5_in = swact_pkg::Y_MAX[swact_pkg::DATA_W-1:0];
      end else if (yw5 < swact_pkg::Y_MIN) begin
         y5_in = swact_pkg::Y_MIN[swact_pkg::DATA_W-1:0];
      end else begin
         y5_in = yw5[swact_pkg::DATA_W-1:0];
      end
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         alpha_gain_ff <= swact_pkg::ALPHA_RESET;
         v1_ff         <= 1'b0;
         v2_ff         <= 1'b0;
         v3_ff         <= 1'b0;
         v4_ff         <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         alpha_gain_ff <= alpha_gain_in;
         if (adv1) v1_ff <= req_valid;
         if (adv2) v2_ff <= v1_ff;
         if (adv3) v3_ff <= v2_ff;
         if (adv4) v4_ff <= v3_ff;
         if (adv5) rsp_valid_ff <= v4_ff;
      end
   end

   // Payload: load only when a valid item moves in
   always_ff @(posedge clock) begin
      if (adv1 && req_valid) begin
         x1_ff <= req_x_value;
         p1_ff <= p1_in;
      end
      if (adv2 && v1_ff) begin
         x2_ff   <= x1_ff;
         lo2_ff  <= lo2_in;
         hi2_ff  <= hi2_in;
         pos2_ff <= pos2_in;
      end
      if (adv3 && v2_ff) begin
         x3_ff     <= x2_ff;
         lo3_ff    <= lo2_ff;
         hi3_ff    <= hi2_ff;
         base3_ff  <= base3_in;
         delta3_ff <= delta3_in;
         frac3_ff  <= frac3_in;
      end
      if (adv4 && v3_ff) begin
         x4_ff   <= x3_ff;
         sig4_ff <= sig4_in;
      end
      if (adv5 && v4_ff) begin
         y5_ff <= y5_in;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_y_value = y5_ff;

   `ASSERT_NEXT(a_accept_fills_s1, req_valid && req_ready, v1_ff)
   `ASSERT_NEXT(a_low_clamp_zero, v3_ff && adv4 && lo3_ff, sig4_ff == '0)
   `ASSERT_NEXT(a_high_clamp_one, v3_ff && adv4 && hi3_ff, sig4_ff == swact_pkg::SIG_ONE)
   `ASSERT_IMPL(a_full_stall_blocks, v1_ff && v2_ff && v3_ff && v4_ff && rsp_valid_ff && !rsp_ready, !req_ready)

endmodule
